@@ rtl/jatp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jatp_pkg: shared constants for the joint angle pipeline
// Fixed internal widths, fixed-point scale points and the CORDIC arctangent
// table in units of 2^-16 degree.
// ----------------------------------------------------------------------------
package jatp_pkg;

    localparam int VEC_BITS     = 19;          // magnitude bits after scaling
    localparam int VEC_W        = VEC_BITS + 1;
    localparam int PROD_W       = 2 * VEC_W;
    localparam int DOT_W        = PROD_W + 2;
    localparam int NRM_W        = 40;
    localparam int ABS_W        = 40;
    localparam int LEN_SCALE    = 24;
    localparam int LEN_IN_W     = 64;
    localparam int LEN_W        = LEN_IN_W / 2;
    localparam int Q1_W         = 35;
    localparam int T_W          = 34;
    localparam int Q2_W         = 31;
    localparam int CMAG_SCALE   = 30;
    localparam int CMAG_W       = 31;
    localparam int SQ_W         = 62;
    localparam int SIN_W        = SQ_W / 2;
    localparam int X_W          = 34;
    localparam int Z_W          = 26;
    localparam int ZC_W         = 25;
    localparam int DEG_BITS     = 16;
    localparam int CORDIC_STEPS = 23;
    localparam int ATAN_W       = 22;

    localparam logic [T_W-1:0]        T_MAX   = T_W'(1) << 33;
    localparam logic [CMAG_W-1:0]     ONE_Q30 = CMAG_W'(1) << CMAG_SCALE;
    localparam logic [SQ_W-1:0]       SIN_ONE = SQ_W'(1) << 60;
    localparam logic signed [Z_W-1:0] Z_QTR   = 26'sd5898240;
    localparam logic signed [Z_W-1:0] Z_FULL  = 26'sd11796480;

    function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned idx);
        case (idx)
            0:  return 22'd2949120;
            1:  return 22'd1740967;
            2:  return 22'd919879;
            3:  return 22'd466945;
            4:  return 22'd234379;
            5:  return 22'd117304;
            6:  return 22'd58666;
            7:  return 22'd29335;
            8:  return 22'd14668;
            9:  return 22'd7334;
            10: return 22'd3667;
            11: return 22'd1833;
            12: return 22'd917;
            13: return 22'd458;
            14: return 22'd229;
            15: return 22'd115;
            16: return 22'd57;
            17: return 22'd29;
            18: return 22'd14;
            19: return 22'd7;
            20: return 22'd4;
            21: return 22'd2;
            22: return 22'd1;
            default: return 22'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ rtl/joint_angle_three_points.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// joint_angle_three_points: angle at vertex B between points A, B and C
// Law of cosines via cos = (u.v)/(|u||v|), u = A-B, v = C-B, then CORDIC
// arccosine; angle in degrees with ANGLE_FRAC_BITS fraction bits.
//
//   channel  | dir | payload
//   s_axis   | in  | tdata: A xyz, B xyz, C xyz (COORD_BITS each, signed)
//   m_axis   | out | tdata: angle_deg; tuser: degenerate
//
// One item accepted per cycle while the output buffer has room; the depth is
// set by the two square roots (32 and 31 stages), the two dividers (35 and 31
// stages) and the 23 CORDIC stages.
// Reset clears all valid bits and the two-entry output buffer.
// The pipeline holds as a whole only while both output entries are occupied.
// ----------------------------------------------------------------------------
module joint_angle_three_points
    import jatp_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 6,
    localparam int IN_DW  = ((9 * COORD_BITS + 7) / 8) * 8,
    localparam int ANG_W  = 8 + ANGLE_FRAC_BITS,
    localparam int OUT_DW = ((ANG_W + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, pivot_x, pivot_y, pivot_z,
    // vertex_c_x, vertex_c_y, vertex_c_z
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // angle_deg
    output logic [OUT_DW-1:0]      m_axis_tdata,
    // degenerate
    output logic                   m_axis_tuser
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS;
    localparam int SH_W   = $clog2(COORD_BITS);
    localparam int SHR    = DEG_BITS - ANGLE_FRAC_BITS;

    logic en;
    logic [1:0] fifo_cnt_reg;

    assign en            = (fifo_cnt_reg != 2'd2);
    assign s_axis_tready = en;

    function automatic logic [SH_W-1:0] shrink_count(input logic [MAG_W-1:0] m);
        logic [SH_W-1:0] k;
        k = '0;
        for (int b = VEC_BITS; b < MAG_W; b++)
            if (m[b])
                k = SH_W'(b - VEC_BITS + 1);
        return k;
    endfunction

    // ---------------- stage 1: differences ----------------
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] u_reg [3];
    logic signed [DIFF_W-1:0] v_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                u_reg[j] <= $signed({s_axis_tdata[j*COORD_BITS + COORD_BITS - 1],
                                     s_axis_tdata[j*COORD_BITS +: COORD_BITS]})
                          - $signed({s_axis_tdata[(j+3)*COORD_BITS + COORD_BITS - 1],
                                     s_axis_tdata[(j+3)*COORD_BITS +: COORD_BITS]});
                v_reg[j] <= $signed({s_axis_tdata[(j+6)*COORD_BITS + COORD_BITS - 1],
                                     s_axis_tdata[(j+6)*COORD_BITS +: COORD_BITS]})
                          - $signed({s_axis_tdata[(j+3)*COORD_BITS + COORD_BITS - 1],
                                     s_axis_tdata[(j+3)*COORD_BITS +: COORD_BITS]});
            end
        end
    end

    // ---------------- stage 2: magnitudes and scale shift ----------------
    logic             s2_valid_reg;
    logic [MAG_W-1:0] umag_reg [3];
    logic [MAG_W-1:0] vmag_reg [3];
    logic             usgn_reg [3];
    logic             vsgn_reg [3];
    logic [SH_W-1:0]  uk_reg, vk_reg;
    logic             s2_degen_reg;
    logic [MAG_W-1:0] umag_next [3];
    logic [MAG_W-1:0] vmag_next [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            umag_next[j] = MAG_W'(u_reg[j] < 0 ? -u_reg[j] : u_reg[j]);
            vmag_next[j] = MAG_W'(v_reg[j] < 0 ? -v_reg[j] : v_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                umag_reg[j] <= umag_next[j];
                vmag_reg[j] <= vmag_next[j];
                usgn_reg[j] <= u_reg[j][DIFF_W-1];
                vsgn_reg[j] <= v_reg[j][DIFF_W-1];
            end
            // highest set bit of the OR equals that of the largest component
            uk_reg       <= shrink_count(umag_next[0] | umag_next[1] | umag_next[2]);
            vk_reg       <= shrink_count(vmag_next[0] | vmag_next[1] | vmag_next[2]);
            s2_degen_reg <= ((umag_next[0] | umag_next[1] | umag_next[2]) == '0)
                         || ((vmag_next[0] | vmag_next[1] | vmag_next[2]) == '0);
        end
    end

    // ---------------- stage 3: scaled components ----------------
    logic                    s3_valid_reg;
    logic signed [VEC_W-1:0] ucmp_reg [3];
    logic signed [VEC_W-1:0] vcmp_reg [3];
    logic                    s3_degen_reg;
    logic [VEC_W-1:0]        ush_next [3];
    logic [VEC_W-1:0]        vsh_next [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            ush_next[j] = VEC_W'(umag_reg[j] >> uk_reg);
            vsh_next[j] = VEC_W'(vmag_reg[j] >> vk_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ucmp_reg[j] <= usgn_reg[j] ? -$signed(ush_next[j]) : $signed(ush_next[j]);
                vcmp_reg[j] <= vsgn_reg[j] ? -$signed(vsh_next[j]) : $signed(vsh_next[j]);
            end
            s3_degen_reg <= s2_degen_reg;
        end
    end

    // ---------------- stage 4: products ----------------
    logic                     s4_valid_reg;
    logic signed [PROD_W-1:0] puv_reg [3];
    logic signed [PROD_W-1:0] puu_reg [3];
    logic signed [PROD_W-1:0] pvv_reg [3];
    logic                     s4_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                puv_reg[j] <= ucmp_reg[j] * vcmp_reg[j];
                puu_reg[j] <= ucmp_reg[j] * ucmp_reg[j];
                pvv_reg[j] <= vcmp_reg[j] * vcmp_reg[j];
            end
            s4_degen_reg <= s3_degen_reg;
        end
    end

    // ---------------- stage 5: sums ----------------
    logic                    s5_valid_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [NRM_W-1:0]        nu_reg, nv_reg;
    logic                    s5_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg <= DOT_W'(puv_reg[0]) + DOT_W'(puv_reg[1]) + DOT_W'(puv_reg[2]);
            nu_reg  <= NRM_W'(puu_reg[0]) + NRM_W'(puu_reg[1]) + NRM_W'(puu_reg[2]);
            nv_reg  <= NRM_W'(pvv_reg[0]) + NRM_W'(pvv_reg[1]) + NRM_W'(pvv_reg[2]);
            s5_degen_reg <= s4_degen_reg;
        end
    end

    // ---------------- stage 6: |dot| and root operands ----------------
    logic                s6_valid_reg;
    logic [ABS_W-1:0]    s6_abs_reg;
    logic                s6_dneg_reg;
    logic [LEN_IN_W-1:0] radu_reg, radv_reg;
    logic                s6_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_abs_reg   <= ABS_W'(dot_reg < 0 ? -dot_reg : dot_reg);
            s6_dneg_reg  <= dot_reg < 0;
            radu_reg     <= {nu_reg, LEN_SCALE'(0)};
            radv_reg     <= {nv_reg, LEN_SCALE'(0)};
            s6_degen_reg <= s5_degen_reg;
        end
    end

    // ---------------- vector lengths ----------------
    logic             lu_valid, lv_valid;
    logic [LEN_W-1:0] lu, lv;
    logic [ABS_W:0]   lu_side;
    logic             lv_side;

    jatp_isqrt #(.IN_W(LEN_IN_W), .SIDE_W(ABS_W + 1)) u_len_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s6_valid_reg),
        .radicand (radu_reg),
        .side_in  ({s6_dneg_reg, s6_abs_reg}),
        .out_valid(lu_valid),
        .root     (lu),
        .side_out (lu_side)
    );

    jatp_isqrt #(.IN_W(LEN_IN_W), .SIDE_W(1)) u_len_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s6_valid_reg),
        .radicand (radv_reg),
        .side_in  (s6_degen_reg),
        .out_valid(lv_valid),
        .root     (lv),
        .side_out (lv_side)
    );

    // ---------------- stage 7: first quotient range check ----------------
    logic             s7_valid_reg;
    logic [ABS_W-1:0] s7_abs_reg;
    logic [LEN_W-1:0] s7_lu_reg, s7_lv_reg;
    logic             s7_dneg_reg, s7_degen_reg, s7_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_abs_reg   <= lu_side[ABS_W-1:0];
            s7_dneg_reg  <= lu_side[ABS_W];
            s7_lu_reg    <= lu;
            s7_lv_reg    <= lv;
            s7_degen_reg <= lv_side;
            s7_ovf_reg   <= LEN_W'(lu_side[ABS_W-1:0] >> (Q1_W - LEN_SCALE)) >= lu;
        end
    end

    // ---------------- t = |dot| * 2^24 / lu ----------------
    logic             d1_valid;
    logic [Q1_W-1:0]  q1;
    logic [LEN_W+2:0] d1_side;

    jatp_div #(.NUM_W(LEN_IN_W), .DEN_W(LEN_W), .Q_W(Q1_W), .SIDE_W(LEN_W + 3)) u_div_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s7_valid_reg),
        .num      ({s7_abs_reg, LEN_SCALE'(0)}),
        .den      (s7_lu_reg),
        .side_in  ({s7_lv_reg, s7_degen_reg, s7_dneg_reg, s7_ovf_reg}),
        .out_valid(d1_valid),
        .quot     (q1),
        .side_out (d1_side)
    );

    // ---------------- stage 8: clamp t ----------------
    logic             s8_valid_reg;
    logic [T_W-1:0]   t_reg;
    logic [LEN_W-1:0] s8_lv_reg;
    logic             s8_degen_reg, s8_dneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d1_side[0] || q1 > Q1_W'(T_MAX))
                t_reg <= T_MAX;
            else
                t_reg <= T_W'(q1);
            s8_lv_reg    <= d1_side[LEN_W+2:3];
            s8_degen_reg <= d1_side[2];
            s8_dneg_reg  <= d1_side[1];
        end
    end

    // ---------------- stage 9: second quotient range check ----------------
    logic             s9_valid_reg;
    logic [T_W-1:0]   s9_t_reg;
    logic [LEN_W-1:0] s9_lv_reg;
    logic             s9_degen_reg, s9_dneg_reg, s9_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_t_reg     <= t_reg;
            s9_lv_reg    <= s8_lv_reg;
            s9_degen_reg <= s8_degen_reg;
            s9_dneg_reg  <= s8_dneg_reg;
            s9_ovf_reg   <= (t_reg >> (CMAG_SCALE + 1 - Q2_W + 1)) >= T_W'(s8_lv_reg);
        end
    end

    // ---------------- cmag = t * 2^30 / lv ----------------
    logic            d2_valid;
    logic [Q2_W-1:0] q2;
    logic [2:0]      d2_side;

    jatp_div #(.NUM_W(LEN_IN_W), .DEN_W(LEN_W), .Q_W(Q2_W), .SIDE_W(3)) u_div_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s9_valid_reg),
        .num      ({s9_t_reg, CMAG_SCALE'(0)}),
        .den      (s9_lv_reg),
        .side_in  ({s9_degen_reg, s9_dneg_reg, s9_ovf_reg}),
        .out_valid(d2_valid),
        .quot     (q2),
        .side_out (d2_side)
    );

    // ---------------- stage 10: clamp cosine ----------------
    logic              s10_valid_reg;
    logic [CMAG_W-1:0] s10_cmag_reg;
    logic              s10_degen_reg, s10_dneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d2_side[0] || q2 > ONE_Q30)
                s10_cmag_reg <= ONE_Q30;
            else
                s10_cmag_reg <= q2;
            s10_degen_reg <= d2_side[2];
            s10_dneg_reg  <= d2_side[1];
        end
    end

    // ---------------- stage 11: cosine squared ----------------
    logic              s11_valid_reg;
    logic [SQ_W-1:0]   s11_sq_reg;
    logic [CMAG_W-1:0] s11_cmag_reg;
    logic              s11_degen_reg, s11_dneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_sq_reg    <= SQ_W'(s10_cmag_reg) * SQ_W'(s10_cmag_reg);
            s11_cmag_reg  <= s10_cmag_reg;
            s11_degen_reg <= s10_degen_reg;
            s11_dneg_reg  <= s10_dneg_reg;
        end
    end

    // ---------------- stage 12: 1 - cos^2 ----------------
    logic              s12_valid_reg;
    logic [SQ_W-1:0]   s12_rad_reg;
    logic [CMAG_W-1:0] s12_cmag_reg;
    logic              s12_degen_reg, s12_dneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s12_rad_reg   <= SIN_ONE - s11_sq_reg;
            s12_cmag_reg  <= s11_cmag_reg;
            s12_degen_reg <= s11_degen_reg;
            s12_dneg_reg  <= s11_dneg_reg;
        end
    end

    // ---------------- sine ----------------
    logic              sn_valid;
    logic [SIN_W-1:0]  sn;
    logic [CMAG_W+1:0] sn_side;

    jatp_isqrt #(.IN_W(SQ_W), .SIDE_W(CMAG_W + 2)) u_sine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s12_valid_reg),
        .radicand (s12_rad_reg),
        .side_in  ({s12_cmag_reg, s12_degen_reg, s12_dneg_reg}),
        .out_valid(sn_valid),
        .root     (sn),
        .side_out (sn_side)
    );

    // ---------------- stage 13: CORDIC start vector ----------------
    logic                  s13_valid_reg;
    logic signed [X_W-1:0] s13_x_reg, s13_y_reg;
    logic signed [Z_W-1:0] s13_z_reg;
    logic                  s13_degen_reg;
    logic [CMAG_W-1:0]     sn_cmag;
    logic                  sn_cneg;

    assign sn_cmag = sn_side[CMAG_W+1:2];
    // a zero cosine counts as non-negative
    assign sn_cneg = sn_side[0] && (sn_cmag != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sn_cneg)
            begin
                s13_x_reg <= $signed(X_W'(sn));
                s13_y_reg <= $signed(X_W'(sn_cmag));
                s13_z_reg <= Z_QTR;
            end
            else
            begin
                s13_x_reg <= $signed(X_W'(sn_cmag));
                s13_y_reg <= $signed(X_W'(sn));
                s13_z_reg <= '0;
            end
            s13_degen_reg <= sn_side[1];
        end
    end

    // ---------------- CORDIC vectoring ----------------
    logic signed [X_W-1:0] cx_reg     [CORDIC_STEPS];
    logic signed [X_W-1:0] cy_reg     [CORDIC_STEPS];
    logic signed [Z_W-1:0] cz_reg     [CORDIC_STEPS];
    logic                  cdeg_reg   [CORDIC_STEPS];
    logic                  cvalid_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [X_W-1:0] x_in, y_in;
        logic signed [Z_W-1:0] z_in;
        logic                  deg_in, valid_in;
        logic signed [Z_W-1:0] atan_c;

        if (i == 0) begin : g_first
            assign x_in     = s13_x_reg;
            assign y_in     = s13_y_reg;
            assign z_in     = s13_z_reg;
            assign deg_in   = s13_degen_reg;
            assign valid_in = s13_valid_reg;
        end else begin : g_next
            assign x_in     = cx_reg[i-1];
            assign y_in     = cy_reg[i-1];
            assign z_in     = cz_reg[i-1];
            assign deg_in   = cdeg_reg[i-1];
            assign valid_in = cvalid_reg[i-1];
        end

        assign atan_c = $signed(Z_W'(atan_q16(i)));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cvalid_reg[i] <= 1'b0;
            else if (en)
                cvalid_reg[i] <= valid_in;
        end

        // rotate toward y = 0; arithmetic shifts round toward minus infinity
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cdeg_reg[i] <= deg_in;
                if (!y_in[X_W-1])
                begin
                    cx_reg[i] <= x_in + (y_in >>> i);
                    cy_reg[i] <= y_in - (x_in >>> i);
                    cz_reg[i] <= z_in + atan_c;
                end
                else
                begin
                    cx_reg[i] <= x_in - (y_in >>> i);
                    cy_reg[i] <= y_in + (x_in >>> i);
                    cz_reg[i] <= z_in - atan_c;
                end
            end
        end
    end

    // ---------------- clamp, round, output buffer ----------------
    logic signed [Z_W-1:0] zl;
    logic [ZC_W-1:0]       zc;
    logic [ZC_W-1:0]       zr;
    logic [ANG_W-1:0]      angle_next;
    logic                  degen_next;
    logic                  push, pop;
    logic [ANG_W-1:0]      e0_angle_reg, e1_angle_reg;
    logic                  e0_degen_reg, e1_degen_reg;

    assign zl = cz_reg[CORDIC_STEPS-1];

    always_comb
    begin
        if (zl < 0)
            zc = '0;
        else if (zl > Z_FULL)
            zc = ZC_W'(Z_FULL);
        else
            zc = ZC_W'(zl);
        zr = (zc + (ZC_W'(1) << (SHR - 1))) >> SHR;
        degen_next = cdeg_reg[CORDIC_STEPS-1];
        angle_next = degen_next ? '0 : ANG_W'(zr);
    end

    assign push = en && cvalid_reg[CORDIC_STEPS-1];
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
            fifo_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (en)
            begin
                s1_valid_reg  <= s_axis_tvalid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                s5_valid_reg  <= s4_valid_reg;
                s6_valid_reg  <= s5_valid_reg;
                s7_valid_reg  <= lu_valid && lv_valid;
                s8_valid_reg  <= d1_valid;
                s9_valid_reg  <= s8_valid_reg;
                s10_valid_reg <= d2_valid;
                s11_valid_reg <= s10_valid_reg;
                s12_valid_reg <= s11_valid_reg;
                s13_valid_reg <= sn_valid;
            end
            case ({push, pop})
                2'b10:   fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
                2'b01:   fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
                default: fifo_cnt_reg <= fifo_cnt_reg;
            endcase
        end
    end

    // head entry drives the ports; second entry catches a result under stall
    always_ff @(posedge clk)
    begin
        case ({push, pop})
            2'b10:
            begin
                if (fifo_cnt_reg == 2'd0)
                begin
                    e0_angle_reg <= angle_next;
                    e0_degen_reg <= degen_next;
                end
                else
                begin
                    e1_angle_reg <= angle_next;
                    e1_degen_reg <= degen_next;
                end
            end
            2'b01:
            begin
                e0_angle_reg <= e1_angle_reg;
                e0_degen_reg <= e1_degen_reg;
            end
            2'b11:
            begin
                e0_angle_reg <= angle_next;
                e0_degen_reg <= degen_next;
            end
            default:
            begin
                e0_angle_reg <= e0_angle_reg;
                e0_degen_reg <= e0_degen_reg;
            end
        endcase
    end

    assign m_axis_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_axis_tdata  = OUT_DW'(e0_angle_reg);
    assign m_axis_tuser  = e0_degen_reg;

endmodule
`default_nettype wire

@@ rtl/jatp_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jatp_isqrt: pipelined integer square root
// One root bit per stage, floor(sqrt(radicand)); a sideband word rides along.
// ----------------------------------------------------------------------------
module jatp_isqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1,
    localparam int OUT_W = IN_W / 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [IN_W-1:0]   radicand,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [OUT_W-1:0]       root,
    output logic [SIDE_W-1:0]      side_out
);

    logic [IN_W:0]       rem_reg   [OUT_W];
    logic [OUT_W-1:0]    root_reg  [OUT_W];
    logic [SIDE_W-1:0]   side_reg  [OUT_W];
    logic                valid_reg [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam int BIT = OUT_W - 1 - k;
        logic [IN_W:0]     rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [SIDE_W-1:0] side_prev;
        logic              valid_prev;
        logic [IN_W:0]     trial;

        if (k == 0) begin : g_first
            assign rem_in     = {1'b0, radicand};
            assign root_in    = '0;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end else begin : g_next
            assign rem_in     = rem_reg[k-1];
            assign root_in    = root_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
        assign trial = ((IN_W+1)'(root_in) << (BIT + 1)) | ((IN_W+1)'(1) << (2 * BIT));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                if (rem_in >= trial)
                begin
                    rem_reg[k]  <= rem_in - trial;
                    root_reg[k] <= root_in | (OUT_W'(1) << BIT);
                end
                else
                begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign side_out  = side_reg[OUT_W-1];

endmodule
`default_nettype wire

@@ rtl/jatp_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jatp_div: pipelined restoring divider
// One quotient bit per stage. The caller guarantees num < den * 2^Q_W and
// flags the other case itself; a sideband word rides along.
// ----------------------------------------------------------------------------
module jatp_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quot,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int CW = DEN_W + Q_W + 1;

    logic [CW-1:0]     rem_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [Q_W-1:0]    quot_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];
    logic              valid_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int BIT = Q_W - 1 - k;
        logic [CW-1:0]     rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    quot_in;
        logic [SIDE_W-1:0] side_prev;
        logic              valid_prev;
        logic [CW-1:0]     dshift;

        if (k == 0) begin : g_first
            assign rem_in     = CW'(num);
            assign den_in     = den;
            assign quot_in    = '0;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end else begin : g_next
            assign rem_in     = rem_reg[k-1];
            assign den_in     = den_reg[k-1];
            assign quot_in    = quot_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        assign dshift = CW'(den_in) << BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                den_reg[k]  <= den_in;
                if (rem_in >= dshift)
                begin
                    rem_reg[k]  <= rem_in - dshift;
                    quot_reg[k] <= quot_in | (Q_W'(1) << BIT);
                end
                else
                begin
                    rem_reg[k]  <= rem_in;
                    quot_reg[k] <= quot_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quot      = quot_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for joint_angle_three_points
// Walks a table of directed point triples, then about a thousand random
// triples through the stream ports. Each result is checked against the table
// value or an in-bench model of the vertex angle computation. The sender works in
// bursts, and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM   = 1000;
    localparam int  IDLE_LIMIT = 20000;
    localparam int  ANG_W      = 14;
    localparam int  ROUND_SH   = 10;
    localparam longint DEG_Q16_180 = 64'sd180 <<< 16;

    typedef logic signed [15:0] coord_t;

    typedef struct {
        coord_t p [9];       // A xyz, B xyz, C xyz
        bit     typed;       // expected value given in the table
        logic [ANG_W-1:0] angle;
        logic   degen;
    } triple_row_t;

    typedef struct {
        logic [ANG_W-1:0] angle;
        logic             degen;
    } angle_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;   // vertex_a xyz, pivot xyz, vertex_c xyz
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;   // angle_deg
    logic         m_axis_tuser;   // degenerate

    angle_result_t pending_angles [$];
    int            err_count;
    int            idle_cycles;

    joint_angle_three_points u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit [63:0] int_sqrt(input bit [63:0] n);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint atan_step(input int idx);
        longint steps [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                               58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                               229, 115, 57, 29, 14, 7, 4, 2, 1};
        return steps[idx];
    endfunction

    // Angle at the pivot by law of cosines and CORDIC arccosine.
    function automatic angle_result_t vertex_angle(input coord_t p [9]);
        angle_result_t res;
        longint u [3];
        longint w [3];
        longint mx_u, mx_w, dot, c, s, x, y, z, xn, yn;
        bit [63:0] nu, nw, lu, lw, t, cmag, q;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'(p[i]) - longint'(p[3+i]);
            w[i] = longint'(p[6+i]) - longint'(p[3+i]);
        end
        res.angle = '0;
        res.degen = 1'b1;
        if ((u[0] == 0 && u[1] == 0 && u[2] == 0) ||
            (w[0] == 0 && w[1] == 0 && w[2] == 0))
            return res;
        mx_u = 0;
        mx_w = 0;
        for (int i = 0; i < 3; i++)
        begin
            if ((u[i] < 0 ? -u[i] : u[i]) > mx_u) mx_u = u[i] < 0 ? -u[i] : u[i];
            if ((w[i] < 0 ? -w[i] : w[i]) > mx_w) mx_w = w[i] < 0 ? -w[i] : w[i];
        end
        // halve toward zero until every component is below 2^19
        while (mx_u >= (64'sd1 <<< 19))
        begin
            for (int i = 0; i < 3; i++) u[i] = u[i] / 2;
            mx_u = mx_u / 2;
        end
        while (mx_w >= (64'sd1 <<< 19))
        begin
            for (int i = 0; i < 3; i++) w[i] = w[i] / 2;
            mx_w = mx_w / 2;
        end
        dot = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
        nu  = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        nw  = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
        lu  = int_sqrt(nu << 24);
        lw  = int_sqrt(nw << 24);
        t   = ($unsigned(dot < 0 ? -dot : dot) << 24) / lu;
        if (t > (64'd1 << 33))
            t = 64'd1 << 33;
        cmag = (t << 30) / lw;
        if (cmag > (64'd1 << 30))
            cmag = 64'd1 << 30;
        c = dot < 0 ? -longint'(cmag) : longint'(cmag);
        s = longint'(int_sqrt((64'd1 << 60) - cmag * cmag));
        if (c >= 0)
        begin
            x = c;
            y = s;
            z = 0;
        end
        else
        begin
            x = s;
            y = -c;
            z = 64'sd90 <<< 16;
        end
        for (int i = 0; i < 23; i++)
        begin
            if (y >= 0)
            begin
                xn = x + (y >>> i);
                yn = y - (x >>> i);
                z  = z + atan_step(i);
            end
            else
            begin
                xn = x - (y >>> i);
                yn = y + (x >>> i);
                z  = z - atan_step(i);
            end
            x = xn;
            y = yn;
        end
        if (z < 0)
            z = 0;
        if (z > DEG_Q16_180)
            z = DEG_Q16_180;
        q = ($unsigned(z) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
        res.angle = q[ANG_W-1:0];
        res.degen = 1'b0;
        return res;
    endfunction

    // Drive one triple and hold it until the transfer; queue its result.
    task automatic send_triple(input coord_t p [9], input bit typed,
                               input angle_result_t typed_res);
        logic [143:0] word;
        for (int i = 0; i < 9; i++)
            word[16*i +: 16] = p[i];
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (typed)
            pending_angles.push_back(typed_res);
        else
            pending_angles.push_back(vertex_angle(p));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_angles.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: cycle through four ready patterns in turn.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            case (($time / 12 / 300) % 4)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("unexpected result: angle_deg %0d", m_axis_tdata[ANG_W-1:0]);
                err_count++;
            end
            else
            begin
                angle_result_t exp_res;
                exp_res = pending_angles.pop_front();
                if (m_axis_tdata !== 16'(exp_res.angle))
                begin
                    $error("angle_deg: expected %0d, got %0d", exp_res.angle, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tuser !== exp_res.degen)
                begin
                    $error("degenerate: expected %0b, got %0b", exp_res.degen, m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic coord_t rnd_coord();
        return coord_t'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        triple_row_t   rows [$];
        triple_row_t   r;
        coord_t        p [9];
        angle_result_t tr;
        int            burst;
        int            mode;
        int            k;

        err_count     = 0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // all points equal, A on pivot, C on pivot
        r.typed = 1; r.angle = 0; r.degen = 1;
        r.p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                      rows.push_back(r);
        r.p = '{5, -7, 9, 5, -7, 9, 100, 2, 3};                  rows.push_back(r);
        r.p = '{100, 2, 3, -32768, 32767, 0, -32768, 32767, 0};  rows.push_back(r);
        // same direction and opposite direction: 0 and 180 degrees
        r.degen = 0;
        r.p = '{10, 0, 0, 0, 0, 0, 20, 0, 0};                    rows.push_back(r);
        r.p = '{32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767};
        rows.push_back(r);
        r.angle = 14'd11520;
        r.p = '{10, 0, 0, 0, 0, 0, -3, 0, 0};                    rows.push_back(r);
        r.p = '{32767, 32767, 32767, 0, 0, 0, -32768, -32768, -32768};
        rows.push_back(r);
        // remaining rows go through the model
        r.typed = 0;
        r.p = '{1, 0, 0, 0, 0, 0, 0, 1, 0};                      rows.push_back(r);
        r.p = '{1, 0, 0, 0, 0, 0, 1, 1, 0};                      rows.push_back(r);
        r.p = '{1, 0, 0, 0, 0, 0, -1, 1, 0};                     rows.push_back(r);
        r.p = '{32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768, 32767};
        rows.push_back(r);
        r.p = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768};
        rows.push_back(r);
        r.p = '{32767, 0, 0, -32768, 0, 0, -32768, 1, 0};        rows.push_back(r);
        r.p = '{32767, 0, 0, -32768, 0, 0, -32767, 0, 0};        rows.push_back(r);
        r.p = '{1, 1, 1, 0, 0, 0, 1, 1, 2};                      rows.push_back(r);
        r.p = '{1000, 1, 0, 0, 0, 0, 1000, 0, 1};                rows.push_back(r);
        r.p = '{-1, -1, -1, 0, 0, 0, 1, 1, 0};                   rows.push_back(r);
        r.p = '{3, 4, 0, 0, 0, 0, 4, -3, 0};                     rows.push_back(r);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (rows[i])
        begin
            tr.angle = rows[i].angle;
            tr.degen = rows[i].degen;
            send_triple(rows[i].p, rows[i].typed, tr);
        end
        wait_drained();

        burst = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                wait_drained();
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
            burst--;
            mode = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++)
                p[i] = rnd_coord();
            case (mode)
                0:
                begin
                    // per component, A or C takes the pivot's coordinate
                    for (int i = 0; i < 3; i++)
                        if ($urandom_range(0, 1) == 1) p[i] = p[3+i];
                        else p[6+i] = p[3+i];
                end
                1:
                begin
                    // end points on one line through the pivot
                    k = $urandom_range(0, 1) ? 2 : -3;
                    for (int i = 0; i < 3; i++)
                    begin
                        p[3+i] = coord_t'($urandom_range(0, 2000)) - 16'sd1000;
                        p[i]   = p[3+i] + coord_t'($urandom_range(0, 600)) - 16'sd300;
                        p[6+i] = p[3+i] + coord_t'(k) * (p[i] - p[3+i]);
                    end
                end
                2, 3, 4, 5: ;
                default:
                begin
                    // short segments around a random pivot
                    for (int i = 0; i < 3; i++)
                    begin
                        p[i]   = p[3+i] + coord_t'($urandom_range(0, 600)) - 16'sd300;
                        p[6+i] = p[3+i] + coord_t'($urandom_range(0, 600)) - 16'sd300;
                    end
                end
            endcase
            send_triple(p, 1'b0, tr);
        end
        wait_drained();
        repeat (400) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ joint_angle_three_points.f @@
rtl/jatp_pkg.sv
rtl/jatp_isqrt.sv
rtl/jatp_div.sv
rtl/joint_angle_three_points.sv
test/tb.sv
